>>> rtl/bth_pkg.sv
// Shared types, codes and defaults for the BER tag-length header decoder.
`default_nettype none

package bth_pkg;

  // Default parameter values.
  localparam int TagBitsDefault      = 32;
  localparam int MaxLenOctetsDefault = 8;

  // Decoder phase codes.
  localparam logic [1:0] PH_TAG_FIRST = 2'd0;
  localparam logic [1:0] PH_TAG_MORE  = 2'd1;
  localparam logic [1:0] PH_LEN_FIRST = 2'd2;
  localparam logic [1:0] PH_LEN_MORE  = 2'd3;

  // Error codes carried in each header result.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_LEN_COUNT = 2'd1;
  localparam logic [1:0] ERR_TAG_OVF   = 2'd2;

  // One incoming header octet.
  typedef struct packed {
    logic [7:0] octet;
    logic       restart;
  } byte_t;

  // One decoded header.
  typedef struct packed {
    logic [1:0]  tag_class;
    logic        constructed;
    logic [31:0] tag_number;
    logic [63:0] length_value;
    logic        indefinite;
    logic        end_of_contents;
    logic [3:0]  header_octets;
    logic [1:0]  error_code;
  } hdr_t;

  // Control state of the decoder: phase and saturating octet count.
  typedef struct packed {
    logic [1:0] phase;
    logic [3:0] count;
  } ctrl_t;

endpackage

`default_nettype wire

>>> rtl/bth_step.sv
// Combinational next-state and result logic for one header octet.
`default_nettype none

module bth_step
  import bth_pkg::*;
#(
  parameter int TAG_BITS       = TagBitsDefault,
  parameter int MAX_LEN_OCTETS = MaxLenOctetsDefault
) (
  input  byte_t                       item,
  input  ctrl_t                       ctrl,
  input  logic [1:0]                  class_reg,
  input  logic                        constructed_reg,
  input  logic [TAG_BITS-1:0]         tag_accum,
  input  logic [63:0]                 length_accum,
  input  logic [$clog2(MAX_LEN_OCTETS+1)-1:0] octets_left,
  output ctrl_t                       ctrl_next,
  output logic [1:0]                  class_next,
  output logic                        constructed_next,
  output logic [TAG_BITS-1:0]         tag_accum_next,
  output logic [63:0]                 length_accum_next,
  output logic [$clog2(MAX_LEN_OCTETS+1)-1:0] octets_left_next,
  output logic                        emit,
  output hdr_t                        result
);

  localparam int LeftW = $clog2(MAX_LEN_OCTETS + 1);

  logic [7:0]           v;
  logic [1:0]           ph;
  logic [3:0]           cnt;
  logic [3:0]           cnt_inc;
  logic [TAG_BITS+6:0]  tag_shift;
  logic [TAG_BITS+31:0] tag_ext;
  logic [63:0]          len_shift;
  logic [LeftW-1:0]     left_dec;
  logic [63:0]          res_len;
  logic                 res_indef;
  logic [1:0]           res_err;

  assign v         = item.octet;
  assign tag_shift = {tag_accum, v[6:0]};
  assign tag_ext   = {32'd0, tag_accum};
  assign len_shift = {length_accum[55:0], v};
  assign left_dec  = (octets_left != '0) ? octets_left - LeftW'(1) : octets_left;

  // A restart drops the partial header before this octet is counted.
  always_comb begin
    ph      = item.restart ? PH_TAG_FIRST : ctrl.phase;
    cnt     = item.restart ? 4'd0 : ctrl.count;
    cnt_inc = (cnt != 4'hF) ? cnt + 4'd1 : cnt;
  end

  // Per-phase decode of the octet.
  always_comb begin
    ctrl_next.phase   = ph;
    ctrl_next.count   = cnt_inc;
    class_next        = class_reg;
    constructed_next  = constructed_reg;
    tag_accum_next    = tag_accum;
    length_accum_next = length_accum;
    octets_left_next  = octets_left;
    emit              = 1'b0;
    res_len           = 64'd0;
    res_indef         = 1'b0;
    res_err           = ERR_NONE;
    case (ph)
      PH_TAG_FIRST: begin
        class_next       = v[7:6];
        constructed_next = v[5];
        if (v[4:0] != 5'h1F) begin
          tag_accum_next  = TAG_BITS'(v[4:0]);
          ctrl_next.phase = PH_LEN_FIRST;
        end else begin
          tag_accum_next  = '0;
          ctrl_next.phase = PH_TAG_MORE;
        end
      end
      PH_TAG_MORE: begin
        // Any set bit in the top seven would be lost by the next shift.
        if (tag_accum[TAG_BITS-1 -: 7] != 7'd0) begin
          emit    = 1'b1;
          res_err = ERR_TAG_OVF;
        end else begin
          tag_accum_next = tag_shift[TAG_BITS-1:0];
          if (!v[7]) begin
            ctrl_next.phase = PH_LEN_FIRST;
          end
        end
      end
      PH_LEN_FIRST: begin
        if (!v[7]) begin
          emit    = 1'b1;
          res_len = {57'd0, v[6:0]};
        end else if (v[6:0] == 7'd0) begin
          emit      = 1'b1;
          res_indef = 1'b1;
        end else if (v[6:0] > 7'(MAX_LEN_OCTETS)) begin
          emit    = 1'b1;
          res_err = ERR_LEN_COUNT;
        end else begin
          octets_left_next  = LeftW'(v[6:0]);
          length_accum_next = 64'd0;
          ctrl_next.phase   = PH_LEN_MORE;
        end
      end
      default: begin
        length_accum_next = len_shift;
        octets_left_next  = left_dec;
        if (left_dec == '0) begin
          emit    = 1'b1;
          res_len = len_shift;
        end
      end
    endcase
    // A finished header rearms the decoder for the next tag.
    if (emit) begin
      ctrl_next.phase = PH_TAG_FIRST;
      ctrl_next.count = 4'd0;
    end
  end

  // Result fields for a completed header.
  always_comb begin
    result.tag_class       = class_reg;
    result.constructed     = constructed_reg;
    result.tag_number      = tag_ext[31:0];
    result.length_value    = res_len;
    result.indefinite      = res_indef;
    result.end_of_contents = (res_err == ERR_NONE) && (class_reg == 2'd0) &&
                             (tag_accum == '0) && !res_indef && (res_len == 64'd0);
    result.header_octets   = cnt_inc;
    result.error_code      = res_err;
  end

endmodule

`default_nettype wire

>>> rtl/bth_out_reg.sv
// Result register that holds a decoded header until it is taken.
`default_nettype none

module bth_out_reg
  import bth_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  hdr_t data_next,
  output logic valid,
  input  logic ready,
  output hdr_t data
);

  // Valid is set by a new result and cleared when the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ber_tlv_header_decoder.sv
// Top level of the BER tag-length header decoder.
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+------------------------------
//  byte     | into      | byte_valid/byte_ready  | byte_data: octet, restart
//  hdr      | out of    | hdr_valid/hdr_ready    | hdr_data: one decoded header
//
// Octets are decoded in their accept cycle, one per cycle while byte_ready is high.
// A header result is registered in the result register the cycle after its last octet.
// Reset returns the decoder to expect a first tag octet and empties the result register.
// A new octet is taken while the result register is empty or being emptied in
// the same cycle, so a stalled result holds back only the byte channel.
`default_nettype none

module ber_tlv_header_decoder
  import bth_pkg::*;
#(
  parameter int TAG_BITS       = TagBitsDefault,
  parameter int MAX_LEN_OCTETS = MaxLenOctetsDefault
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  byte_valid,
  output logic  byte_ready,
  input  byte_t byte_data,
  output logic  hdr_valid,
  input  logic  hdr_ready,
  output hdr_t  hdr_data
);

  localparam int LeftW = $clog2(MAX_LEN_OCTETS + 1);

  ctrl_t               ctrl;
  ctrl_t               ctrl_next;
  logic [1:0]          class_reg;
  logic [1:0]          class_next;
  logic                constructed_reg;
  logic                constructed_next;
  logic [TAG_BITS-1:0] tag_accum;
  logic [TAG_BITS-1:0] tag_accum_next;
  logic [63:0]         length_accum;
  logic [63:0]         length_accum_next;
  logic [LeftW-1:0]    octets_left;
  logic [LeftW-1:0]    octets_left_next;
  logic                emit;
  hdr_t                result;
  logic                accept;

  assign byte_ready = !hdr_valid || hdr_ready;
  assign accept     = byte_valid && byte_ready;

  bth_step #(
    .TAG_BITS       (TAG_BITS),
    .MAX_LEN_OCTETS (MAX_LEN_OCTETS)
  ) u_step (
    .item              (byte_data),
    .ctrl              (ctrl),
    .class_reg         (class_reg),
    .constructed_reg   (constructed_reg),
    .tag_accum         (tag_accum),
    .length_accum      (length_accum),
    .octets_left       (octets_left),
    .ctrl_next         (ctrl_next),
    .class_next        (class_next),
    .constructed_next  (constructed_next),
    .tag_accum_next    (tag_accum_next),
    .length_accum_next (length_accum_next),
    .octets_left_next  (octets_left_next),
    .emit              (emit),
    .result            (result)
  );

  // Control state advances on every accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.phase <= PH_TAG_FIRST;
      ctrl.count <= 4'd0;
    end else if (accept) begin
      ctrl <= ctrl_next;
    end
  end

  // Header fields gathered so far; each is written before it is read.
  always_ff @(posedge clk) begin
    if (accept) begin
      class_reg       <= class_next;
      constructed_reg <= constructed_next;
      tag_accum       <= tag_accum_next;
      length_accum    <= length_accum_next;
      octets_left     <= octets_left_next;
    end
  end

  bth_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && emit),
    .data_next (result),
    .valid     (hdr_valid),
    .ready     (hdr_ready),
    .data      (hdr_data)
  );

endmodule

`default_nettype wire

>>> test/tb_ber_tlv_header_decoder.sv
// Self-checking testbench for the BER tag-length header decoder.
`timescale 1ns / 100ps

module tb_ber_tlv_header_decoder;
  import bth_pkg::*;

  // Run length, timeout and receiver stall modes.
  localparam int ITEM_TARGET   = 1950;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int HOLD_OFF_LONG = 250;
  localparam int RX_ALWAYS     = 0;
  localparam int RX_COIN       = 1;
  localparam int RX_PATTERN    = 2;

  // Header octet values the decoder treats specially.
  localparam logic [4:0] TAG_ESCAPE      = 5'h1F;
  localparam logic [1:0] CLASS_UNIVERSAL = 2'd0;

  logic  clk = 1'b0;
  logic  rst;
  logic  byte_valid;
  logic  byte_ready;
  byte_t byte_data;
  logic  hdr_valid;
  logic  hdr_ready = 1'b0;
  hdr_t  hdr_data;

  // Headers the decoder is expected to produce, oldest first.
  hdr_t expected_hdrs[$];
  int   mismatch_count = 0;
  int   octets_sent = 0;

  // Sender and receiver pacing controls.
  bit          gaps_on = 1'b1;
  int unsigned burst_left = 0;
  int          rx_mode = RX_COIN;
  logic [15:0] rx_pattern = 16'hB5A3;
  int          hold_off_cycles = 0;

  // Shadow copy of the decoder state.
  logic [1:0]  dec_phase;
  logic [1:0]  dec_class;
  logic        dec_cons;
  logic [31:0] dec_tag;
  logic [63:0] dec_len;
  logic [6:0]  dec_left;
  logic [3:0]  dec_count;

  ber_tlv_header_decoder u_top (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .hdr_valid  (hdr_valid),
    .hdr_ready  (hdr_ready),
    .hdr_data   (hdr_data)
  );

  // Free-running clock, 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Clear the shadow state so the next octet is read as a first tag octet.
  task automatic rearm_decoder();
    dec_phase = PH_TAG_FIRST;
    dec_class = '0;
    dec_cons  = 1'b0;
    dec_tag   = '0;
    dec_len   = '0;
    dec_left  = '0;
    dec_count = '0;
  endtask

  // Queue one finished header and start over.
  task automatic finish_header(input logic [63:0] len, input logic indef,
                               input logic [1:0] err);
    hdr_t h;
    h.tag_class       = dec_class;
    h.constructed     = dec_cons;
    h.tag_number      = dec_tag;
    h.length_value    = len;
    h.indefinite      = indef;
    h.end_of_contents = (err == ERR_NONE) && (dec_class == CLASS_UNIVERSAL) &&
                        (dec_tag == '0) && !indef && (len == '0);
    h.header_octets   = dec_count;
    h.error_code      = err;
    expected_hdrs.push_back(h);
    rearm_decoder();
  endtask

  // Advance the shadow decoder by one accepted octet.
  task automatic decode_octet(input byte_t b);
    if (b.restart) begin
      rearm_decoder();
    end
    if (dec_count != 4'd15) begin
      dec_count = dec_count + 4'd1;
    end
    case (dec_phase)
      PH_TAG_FIRST: begin
        dec_class = b.octet[7:6];
        dec_cons  = b.octet[5];
        if (b.octet[4:0] != TAG_ESCAPE) begin
          dec_tag   = {27'd0, b.octet[4:0]};
          dec_phase = PH_LEN_FIRST;
        end else begin
          dec_tag   = '0;
          dec_phase = PH_TAG_MORE;
        end
      end
      PH_TAG_MORE: begin
        // A further group would push set bits out of the tag accumulator.
        if ((dec_tag >> (TagBitsDefault - 7)) != '0) begin
          finish_header(64'd0, 1'b0, ERR_TAG_OVF);
        end else begin
          dec_tag = {dec_tag[24:0], b.octet[6:0]};
          if (!b.octet[7]) begin
            dec_phase = PH_LEN_FIRST;
          end
        end
      end
      PH_LEN_FIRST: begin
        if (!b.octet[7]) begin
          finish_header({57'd0, b.octet[6:0]}, 1'b0, ERR_NONE);
        end else if (b.octet[6:0] == 7'd0) begin
          finish_header(64'd0, 1'b1, ERR_NONE);
        end else if (b.octet[6:0] > MaxLenOctetsDefault) begin
          finish_header(64'd0, 1'b0, ERR_LEN_COUNT);
        end else begin
          dec_left  = b.octet[6:0];
          dec_len   = '0;
          dec_phase = PH_LEN_MORE;
        end
      end
      default: begin
        dec_len = {dec_len[55:0], b.octet};
        if (dec_left != '0) begin
          dec_left = dec_left - 7'd1;
        end
        if (dec_left == '0) begin
          finish_header(dec_len, 1'b0, ERR_NONE);
        end
      end
    endcase
  endtask

  // Offer one octet, wait for the transaction, then maybe idle between bursts.
  task automatic push_octet(input byte_t b);
    @(negedge clk);
    byte_data  = b;
    byte_valid = 1'b1;
    do @(posedge clk); while (!byte_ready);
    decode_octet(b);
    octets_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        repeat ($urandom_range(1, 6)) begin
          @(negedge clk);
          byte_valid        = 1'b0;
          byte_data.octet   = 8'($urandom);
          byte_data.restart = 1'($urandom);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  // Send the lowest n octets of seq, most significant first.
  task automatic send_seq(input int n, input logic [159:0] seq, input logic rs);
    byte_t b;
    for (int i = n - 1; i >= 0; i--) begin
      b.octet   = seq[i*8 +: 8];
      b.restart = (i == n - 1) ? rs : 1'b0;
      push_octet(b);
    end
  endtask

  // Hold the sender until every expected header has come out.
  task automatic wait_drained();
    int n;
    n = 0;
    @(negedge clk);
    byte_valid = 1'b0;
    while (expected_hdrs.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
  endtask

  // Short tag forms with short and indefinite lengths across the four classes.
  task automatic test_short_form();
    rx_mode = RX_COIN;
    send_seq(2, 16'h00_00, 1'b0);
    send_seq(2, 16'h20_00, 1'b0);
    send_seq(2, 16'h30_80, 1'b0);
    send_seq(2, 16'h5E_7F, 1'b0);
    send_seq(2, 16'h80_00, 1'b0);
    send_seq(2, 16'hFE_05, 1'b0);
  endtask

  // Base-128 tag numbers: small values, the largest value, overflow, saturation.
  task automatic test_long_tags();
    rx_mode = RX_PATTERN;
    send_seq(3, 24'h1F_05_00, 1'b0);
    send_seq(7, 56'h1F_8F_FF_FF_FF_7F_01, 1'b0);
    send_seq(6, 48'h1F_90_80_80_80_00, 1'b0);
    send_seq(17, {8'h1F, {14{8'h80}}, 8'h01, 8'h00}, 1'b0);
  endtask

  // Long-form lengths, the count limit, the reserved count, a zero length and the indefinite form.
  task automatic test_length_forms();
    rx_mode = RX_ALWAYS;
    send_seq(4, 32'h02_82_01_00, 1'b0);
    send_seq(10, 80'h04_88_FF_FF_FF_FF_FF_FF_FF_FF, 1'b0);
    send_seq(2, 16'h04_89, 1'b0);
    send_seq(2, 16'h04_FF, 1'b0);
    send_seq(3, 24'h00_81_00, 1'b0);
    send_seq(2, 16'h00_80, 1'b0);
  endtask

  // Restart drops a partial tag, a partial length, or nothing at all.
  task automatic test_restart();
    rx_mode = RX_COIN;
    send_seq(2, 16'h1F_81, 1'b0);
    send_seq(2, 16'h02_01, 1'b1);
    send_seq(3, 24'h04_84_12, 1'b0);
    send_seq(2, 16'h30_80, 1'b1);
    send_seq(2, 16'h02_05, 1'b1);
  endtask

  // Long receiver hold-off while the sender keeps offering headers.
  task automatic test_backpressure();
    wait_drained();
    gaps_on         = 1'b0;
    hold_off_cycles = HOLD_OFF_LONG;
    repeat (30) begin
      send_seq(2, {8'($urandom_range(0, 30)), 1'b0, 7'($urandom)}, 1'b0);
    end
    wait_drained();
    gaps_on = 1'b1;
  endtask

  // A few random octets that usually knock the stream out of step.
  task automatic send_noise();
    byte_t b;
    repeat ($urandom_range(1, 4)) begin
      b.octet   = 8'($urandom);
      b.restart = 1'($urandom);
      push_octet(b);
    end
  endtask

  // One header with random content; a few are cut short.
  task automatic send_random_header();
    logic [7:0]  hq[$];
    int unsigned pick;
    int unsigned groups;
    int unsigned nlen;
    int unsigned cut;
    byte_t       b;
    logic        rs;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      hq.push_back({2'($urandom), 1'($urandom), 5'($urandom_range(0, 30))});
    end else begin
      hq.push_back({2'($urandom), 1'($urandom), TAG_ESCAPE});
      groups = $urandom_range(1, 5);
      for (int g = 0; g < groups; g++) begin
        hq.push_back({g != groups - 1, 7'($urandom)});
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      hq.push_back({1'b0, 7'($urandom)});
    end else if (pick < 50) begin
      hq.push_back(8'h80);
    end else if (pick < 92) begin
      nlen = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 3);
      hq.push_back(8'h80 | 8'(nlen));
      repeat (nlen) hq.push_back(8'($urandom));
    end else begin
      hq.push_back({1'b1, 7'($urandom_range(9, 127))});
    end
    // Truncated header, picked up later by a restart.
    if ($urandom_range(0, 15) == 0) begin
      cut = $urandom_range(1, hq.size() - 1);
      hq  = hq[0:cut-1];
    end
    // Resync with a restart when the decoder is out of step, sometimes anyway.
    rs = (dec_phase != PH_TAG_FIRST) || ($urandom_range(0, 4) == 0);
    foreach (hq[i]) begin
      b.octet   = hq[i];
      b.restart = (i == 0) ? rs : 1'b0;
      push_octet(b);
    end
  endtask

  // Random headers in segments with changing sender and receiver pacing.
  task automatic test_random_stream();
    int seg_end;
    while (octets_sent < ITEM_TARGET) begin
      seg_end    = octets_sent + $urandom_range(80, 250);
      rx_mode    = $urandom_range(RX_ALWAYS, RX_PATTERN);
      rx_pattern = 16'($urandom) | 16'h0001;
      gaps_on    = ($urandom_range(0, 3) != 0);
      while (octets_sent < seg_end) begin
        if ($urandom_range(0, 19) == 0) begin
          send_noise();
        end else begin
          send_random_header();
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        wait_drained();
      end
    end
  endtask

  // Receiver ready, driven at the falling edge; long hold-offs take priority.
  initial begin : hdr_receiver
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        hdr_ready = 1'b0;
        hold_off_cycles--;
      end else begin
        case (rx_mode)
          RX_ALWAYS: hdr_ready = 1'b1;
          RX_COIN:   hdr_ready = ($urandom_range(0, 2) != 0);
          default: begin
            hdr_ready  = rx_pattern[0];
            rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
          end
        endcase
      end
    end
  end

  task automatic report_mismatch(input string what, input hdr_t want, input hdr_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: header mismatch (%s)", $realtime, what);
      $display("  exp cls=%0d c=%0b tag=%h len=%h ind=%0b eoc=%0b n=%0d err=%0d",
               want.tag_class, want.constructed, want.tag_number, want.length_value,
               want.indefinite, want.end_of_contents, want.header_octets,
               want.error_code);
      $display("  got cls=%0d c=%0b tag=%h len=%h ind=%0b eoc=%0b n=%0d err=%0d",
               got.tag_class, got.constructed, got.tag_number, got.length_value,
               got.indefinite, got.end_of_contents, got.header_octets, got.error_code);
    end
  endtask

  // Compare every header transaction with the oldest expectation.
  always @(posedge clk) begin : hdr_checker
    hdr_t  want;
    string bad;
    if (!rst && hdr_valid && hdr_ready) begin
      if (expected_hdrs.size() == 0) begin
        report_mismatch("no header expected", '0, hdr_data);
      end else begin
        want = expected_hdrs.pop_front();
        bad  = "";
        if (hdr_data.tag_class != want.tag_class) bad = {bad, " tag_class"};
        if (hdr_data.constructed != want.constructed) bad = {bad, " constructed"};
        if (hdr_data.tag_number != want.tag_number) bad = {bad, " tag_number"};
        if (hdr_data.length_value != want.length_value) bad = {bad, " length_value"};
        if (hdr_data.indefinite != want.indefinite) bad = {bad, " indefinite"};
        if (hdr_data.end_of_contents != want.end_of_contents) bad = {bad, " eoc"};
        if (hdr_data.header_octets != want.header_octets) bad = {bad, " header_octets"};
        if (hdr_data.error_code != want.error_code) bad = {bad, " error_code"};
        if (bad != "") begin
          report_mismatch(bad, want, hdr_data);
        end
      end
    end
  end

  // Main sequence: reset, directed tests, random stream, final verdict.
  initial begin : main_seq
    rst        = 1'b1;
    byte_valid = 1'b0;
    byte_data  = '0;
    rearm_decoder();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_short_form();
    test_long_tags();
    test_length_forms();
    test_restart();
    test_backpressure();
    test_random_stream();
    @(negedge clk);
    byte_valid = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (expected_hdrs.size() != 0) begin
      $display("%0d expected headers never arrived", expected_hdrs.size());
      mismatch_count += expected_hdrs.size();
    end
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
